// File: rtl/cac_pkg.sv
`timescale 1ns / 1ps

package cac_pkg;

  localparam int MAX_VARS = 4096;
  localparam int MEM_DEPTH = 2 * MAX_VARS;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam int NV_W = 13;
  localparam int VAR_W = 13;
  localparam int LIT_W = 15;
  localparam int CNT_W = 16;

  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_FIELD_W = 2 + CNT_W;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_TRANSITION_MODE = 1'b0,
    CFG_NUM_VARS        = 1'b1
  } cfg_idx_e;

  // One item after its memory lookup has been issued
  typedef struct packed {
    logic valid;
    logic restart;
    logic in_range;
    logic neg;
    logic last;
  } lookup_t;

  typedef struct packed {
    logic [CNT_W-1:0] clause_count;
    logic             all_satisfied;
    logic             clause_satisfied;
  } result_t;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic frame,
                                                   input logic [LIT_W-1:0] var_idx);
    logic [ADDR_W-1:0] base;
    logic [LIT_W-1:0]  offs;
    base = frame ? ADDR_W'(MAX_VARS) : '0;
    offs = var_idx - LIT_W'(1);
    return base + ADDR_W'(offs);
  endfunction

endpackage

// File: rtl/cac_ram.sv
`timescale 1ns / 1ps

module cac_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cac_lookup.sv
`timescale 1ns / 1ps

module cac_lookup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [1:0]                  kind_i,
  input  logic                        frame_i,
  input  logic [cac_pkg::VAR_W-1:0]   variable_i,
  input  logic                        value_true_i,
  input  logic [cac_pkg::LIT_W-1:0]   literal_i,
  input  logic                        last_i,
  input  logic                        transition_mode_i,
  input  logic [cac_pkg::NV_W-1:0]    num_vars_i,
  output logic                        we_o,
  output logic [cac_pkg::ADDR_W-1:0]  waddr_o,
  output logic                        wdata_o,
  output logic                        re_o,
  output logic [cac_pkg::ADDR_W-1:0]  raddr_o,
  output cac_pkg::lookup_t            stage_o
);

  logic                       neg;
  logic [cac_pkg::LIT_W-1:0]  mag;
  logic [cac_pkg::LIT_W-1:0]  nv_ext;
  logic                       hi_frame;
  logic [cac_pkg::LIT_W-1:0]  idx;
  logic                       in_range;
  logic                       load_ok;
  logic                       is_lit;
  logic                       is_restart;
  cac_pkg::lookup_t           stage_d;
  cac_pkg::lookup_t           stage_q;

  always_comb begin
    neg      = literal_i[cac_pkg::LIT_W-1];
    mag      = neg ? (cac_pkg::LIT_W'(0) - literal_i) : literal_i;
    nv_ext   = cac_pkg::LIT_W'(num_vars_i);
    // Variables past the frame size go to frame 1 in transition mode
    hi_frame = transition_mode_i && (mag > nv_ext);
    idx      = hi_frame ? (mag - nv_ext) : mag;
    in_range = (idx != '0) && (idx <= nv_ext) && (32'(idx) <= cac_pkg::MAX_VARS);
    load_ok  = (variable_i != '0) && (32'(variable_i) <= cac_pkg::MAX_VARS);

    is_lit     = 1'b0;
    is_restart = 1'b0;
    case (kind_i)
      cac_pkg::KIND_LITERAL: is_lit = 1'b1;
      cac_pkg::KIND_RESTART: is_restart = 1'b1;
      default: ;
    endcase
  end

  assign we_o    = accept_i && (kind_i == cac_pkg::KIND_LOAD) && load_ok;
  assign waddr_o = cac_pkg::frame_addr(frame_i, cac_pkg::LIT_W'(variable_i));
  assign wdata_o = value_true_i;
  assign re_o    = accept_i && is_lit;
  assign raddr_o = cac_pkg::frame_addr(hi_frame, idx);

  always_comb begin
    stage_d          = '0;
    stage_d.valid    = accept_i && (is_lit || is_restart);
    stage_d.restart  = is_restart;
    stage_d.in_range = in_range;
    stage_d.neg      = neg;
    stage_d.last     = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// File: rtl/cac_eval.sv
`timescale 1ns / 1ps

module cac_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cac_pkg::lookup_t  stage_i,
  input  logic              bit_i,
  output logic              push_o,
  output cac_pkg::result_t  result_o
);

  logic                      clause_q, clause_d;
  logic                      all_q, all_d;
  logic [cac_pkg::CNT_W-1:0] count_q, count_d;
  logic                      lit_true;
  logic                      clause_now;

  always_comb begin
    lit_true   = stage_i.in_range && (stage_i.neg ? !bit_i : bit_i);
    clause_now = clause_q || lit_true;
    clause_d   = clause_q;
    all_d      = all_q;
    count_d    = count_q;
    push_o     = 1'b0;
    if (stage_i.valid) begin
      if (stage_i.restart) begin
        clause_d = 1'b0;
        all_d    = 1'b1;
        count_d  = '0;
      end else if (stage_i.last) begin
        clause_d = 1'b0;
        all_d    = all_q && clause_now;
        // saturate the clause count
        if (count_q != '1) begin
          count_d = count_q + cac_pkg::CNT_W'(1);
        end
        push_o = 1'b1;
      end else begin
        clause_d = clause_now;
      end
    end
    result_o.clause_satisfied = clause_now;
    result_o.all_satisfied    = all_d;
    result_o.clause_count     = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clause_q <= 1'b0;
      all_q    <= 1'b1;
      count_q  <= '0;
    end else begin
      clause_q <= clause_d;
      all_q    <= all_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/cac_outq.sv
`timescale 1ns / 1ps

module cac_outq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  cac_pkg::result_t             data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output cac_pkg::result_t             data_o,
  output logic [cac_pkg::OQ_CNT_W-1:0] count_o
);

  cac_pkg::result_t                entry_q [cac_pkg::OQ_DEPTH];
  logic [cac_pkg::OQ_PTR_W-1:0]    wptr_q, wptr_d;
  logic [cac_pkg::OQ_PTR_W-1:0]    rptr_q, rptr_d;
  logic [cac_pkg::OQ_CNT_W-1:0]    count_q, count_d;
  logic                            do_pop;

  always_comb begin
    do_pop  = pop_i && (count_q != '0);
    wptr_d  = push_i ? wptr_q + cac_pkg::OQ_PTR_W'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + cac_pkg::OQ_PTR_W'(1) : rptr_q;
    count_d = count_q + cac_pkg::OQ_CNT_W'(push_i) - cac_pkg::OQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rptr_q];
  assign count_o = count_q;

endmodule

// File: rtl/cnf_assignment_checker_top.sv
`timescale 1ns / 1ps

// CNF clause checker. Load transactions write one truth bit per variable into
// frame 0 or 1 of an on-chip assignment memory (2 x 4096 bits, contents
// undefined until loaded; no clearing pass after reset). Literal transactions
// read that memory and OR into the running clause result; a literal with tlast
// set ends the clause and yields one result transaction with the clause flag,
// the sticky all-clauses flag and a saturating clause count. Restart clears
// the clause flag and the count and sets the all-clauses flag. One transaction
// is accepted per clock while s_axis_tready is high; a result passes through
// the registered read of the assignment memory and then a four-entry output
// queue, so the input keeps flowing while the consumer stalls briefly. A load
// is visible to a literal accepted in the very next cycle.
module cnf_assignment_checker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [cac_pkg::NV_W-1:0]        cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // frame[0], variable[13:1], value_true[14], literal[29:15], zero[31:30]
  input  logic [cac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // clause_satisfied[0], all_satisfied[1], clause_count[17:2], zero[23:18]
  output logic [cac_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                            tmode_q;
  logic [cac_pkg::NV_W-1:0]        nvars_q;
  logic                            accept;
  logic                            we;
  logic [cac_pkg::ADDR_W-1:0]      waddr;
  logic                            wdata;
  logic                            re;
  logic [cac_pkg::ADDR_W-1:0]      raddr;
  logic                            rbit;
  cac_pkg::lookup_t                stage;
  logic                            push;
  cac_pkg::result_t                result;
  cac_pkg::result_t                head;
  logic [cac_pkg::OQ_CNT_W-1:0]    q_count;
  logic [cac_pkg::OQ_CNT_W-1:0]    pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmode_q <= 1'b0;
      nvars_q <= cac_pkg::NV_W'(cac_pkg::MAX_VARS);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cac_pkg::CFG_TRANSITION_MODE: tmode_q <= cfg_data_i[0];
        cac_pkg::CFG_NUM_VARS:        nvars_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Reserve queue room for the item in the eval stage and the one entering now
  assign pending       = q_count + cac_pkg::OQ_CNT_W'(stage.valid && !stage.restart
                                                      && stage.last);
  assign s_axis_tready = (pending <= cac_pkg::OQ_CNT_W'(cac_pkg::OQ_DEPTH - 2));
  assign accept        = s_axis_tvalid && s_axis_tready;

  cac_lookup u_lookup (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .kind_i            (s_axis_tuser),
    .frame_i           (s_axis_tdata[0]),
    .variable_i        (s_axis_tdata[13:1]),
    .value_true_i      (s_axis_tdata[14]),
    .literal_i         (s_axis_tdata[29:15]),
    .last_i            (s_axis_tlast),
    .transition_mode_i (tmode_q),
    .num_vars_i        (nvars_q),
    .we_o              (we),
    .waddr_o           (waddr),
    .wdata_o           (wdata),
    .re_o              (re),
    .raddr_o           (raddr),
    .stage_o           (stage)
  );

  cac_ram #(
    .WIDTH (1),
    .DEPTH (cac_pkg::MEM_DEPTH)
  ) u_assign_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rbit)
  );

  cac_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .bit_i    (rbit),
    .push_o   (push),
    .result_o (result)
  );

  cac_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (head),
    .count_o (q_count)
  );

  assign m_axis_tdata = {(cac_pkg::OUT_TDATA_W - cac_pkg::OUT_FIELD_W)'(0), head};

endmodule
